@@ design/gsp_pkg.sv @@
package gsp_pkg;

  // number of slot cells; the slot and capacity fields are sized for 16
  localparam int SLOTS = 16;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_LEASED   = 2'd2;

  localparam logic [1:0] FN_RESERVE   = 2'd0;
  localparam logic [1:0] FN_COMMIT    = 2'd1;
  localparam logic [1:0] FN_REL_RESV  = 2'd2;
  localparam logic [1:0] FN_REL_LEASE = 2'd3;

  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_INVALID   = 3'd1;
  localparam logic [2:0] RS_EXHAUSTED = 3'd2;
  localparam logic [2:0] RS_CONTRACT  = 3'd3;
  localparam logic [2:0] RS_IGNORED   = 3'd4;

  // Per-cycle command seen by every slot cell.
  typedef struct packed {
    logic       grant;      // reserve pass: claim if token and free
    logic       addr_hit;   // commit/release: write addressed slot
    logic [1:0] new_status;
  } cell_cmd_t;

endpackage

@@ design/gsp_cell.sv @@
// One slot: status and generation. The scan token enters from the lower
// neighbor and leaves toward the upper one.
module gsp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_cap_i,
  input  gsp_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  logic               tok_i,
  output logic               tok_o,
  output logic               claim_o,
  output logic [1:0]         status_o,
  output logic [63:0]        gen_o
);
  logic [1:0]  status_q, status_d;
  logic [63:0] gen_q, gen_d;
  logic        free_ok;

  assign free_ok  = in_cap_i && (status_q == gsp_pkg::ST_FREE);
  // first free slot above an already-passed token claims
  assign claim_o  = cmd_i.grant && tok_i && free_ok;
  assign tok_o    = tok_i && !claim_o;
  assign status_o = status_q;
  assign gen_o    = gen_q;

  always_comb begin
    status_d = status_q;
    gen_d    = gen_q;
    if (claim_o) begin
      status_d = gsp_pkg::ST_RESERVED;
      gen_d    = (gen_q == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd1 : gen_q + 64'd1;
    end else if (cmd_i.addr_hit && sel_i) begin
      status_d = cmd_i.new_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= gsp_pkg::ST_FREE;
      gen_q    <= '0;
    end else begin
      status_q <= status_d;
      gen_q    <= gen_d;
    end
  end
endmodule

@@ design/generational_slot_pool_unit.sv @@
// Generational slot pool: row of slot cells with a one-claim-per-cycle scan while the output is not stalled.
// A commit, release or failed reserve is checked in S_EVAL and its single beat
// is registered into the output register; a reserve is checked in S_EVAL and
// then emits one grant beat per cycle from S_SCAN while the output is not stalled.
// One item at a time: the next is taken in S_IDLE, after the last beat has left.
// Reset (rst_ni async low): all slots free, generations, counts zero, cap 16.
module generational_slot_pool_unit #(
  parameter int MAX_GRANT = 16,
  parameter int MAX_CHUNK = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_wdata_i,     // capacity
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [1:0]    s_axis_tuser_i,  // [1:0] func
  // [63:0] req_grant, [68:64] req_count, [72:69] req_slot,
  // [136:73] generation, [147:137] chunk_size, zero pad to 152
  input  logic [151:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [2:0] status, [66:3] grant_echo, [70:67] out_slot, [134:71] out_generation,
  // [145:135] out_size, [150:146] reserved_total, [155:151] leased_total,
  // [219:156] copies_total, zero pad to 224
  output logic [223:0]  m_axis_tdata_o,
  output logic          m_axis_tlast_o
);
  localparam int SLOTS = gsp_pkg::SLOTS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0, S_EVAL = 2'd1, S_SCAN = 2'd2, S_OUT = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [4:0]   cap_q;
  logic [147:0] in_q;
  logic [1:0]   func_q;
  logic [63:0]  copy_q;
  logic [4:0]   left_q;       // grants still to emit
  logic         out_v_q;
  logic [223:0] out_q;
  logic         out_last_q;

  logic [1:0]  func;
  logic [63:0] req_grant, gen_in;
  logic [4:0]  bcount;
  logic [3:0]  sidx;
  logic [10:0] csize;
  assign func      = func_q;
  assign req_grant = in_q[63:0];
  assign bcount    = in_q[68:64];
  assign sidx      = in_q[72:69];
  assign gen_in    = in_q[136:73];
  assign csize     = in_q[147:137];

  logic [4:0] ecap;
  assign ecap = (cap_q == 5'd0 || 32'(cap_q) > SLOTS) ? 5'd0 : cap_q;

  gsp_pkg::cell_cmd_t cmd;
  logic [SLOTS:0]   tok;
  logic [SLOTS-1:0] claim, incap, sel;
  logic [1:0]       st [SLOTS];
  logic [63:0]      gn [SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign incap[g] = 32'(g) < 32'(ecap);
    assign sel[g]   = 32'(sidx) == g;
    gsp_cell u_cell (
      .clk_i, .rst_ni, .in_cap_i(incap[g]), .cmd_i(cmd), .sel_i(sel[g]),
      .tok_i(tok[g]), .tok_o(tok[g+1]), .claim_o(claim[g]),
      .status_o(st[g]), .gen_o(gn[g])
    );
  end
  assign tok[0] = 1'b1;

  // population counts over live cells; SLOTS small, flat adder tree
  logic [CW-1:0] n_free, n_res, n_lea;
  always_comb begin
    n_free = '0; n_res = '0; n_lea = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (incap[i] && st[i] == gsp_pkg::ST_FREE)     n_free = n_free + 1'b1;
      if (incap[i] && st[i] == gsp_pkg::ST_RESERVED) n_res  = n_res + 1'b1;
      if (incap[i] && st[i] == gsp_pkg::ST_LEASED)   n_lea  = n_lea + 1'b1;
    end
  end

  // claimed slot index (one-hot encode)
  logic [IW-1:0] cidx;
  logic [63:0]   cgen;
  always_comb begin
    cidx = '0;
    cgen = '0;
    for (int i = 0; i < SLOTS; i++)
      if (claim[i]) begin
        cidx = IW'(i);
        cgen = (gn[i] == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd1 : gn[i] + 64'd1;
      end
  end

  logic        idx_ok, gen_eq;
  logic [1:0]  cur_st;
  logic [63:0] cur_gen;
  always_comb begin
    cur_st  = gsp_pkg::ST_FREE;
    cur_gen = '0;
    for (int i = 0; i < SLOTS; i++)
      if (sel[i]) begin
        cur_st  = st[i];
        cur_gen = gn[i];
      end
  end
  assign idx_ok = 32'(sidx) < 32'(ecap);
  assign gen_eq = cur_gen == gen_in;

  logic res_bad, com_ok, rel_ok;
  assign res_bad = req_grant == '0 || ecap == '0 || bcount == '0 || bcount > ecap ||
                   32'(bcount) > MAX_GRANT;
  assign com_ok  = idx_ok && csize != '0 && 32'(csize) <= MAX_CHUNK &&
                   cur_st == gsp_pkg::ST_RESERVED && gen_eq;
  assign rel_ok  = idx_ok && gen_eq &&
                   cur_st == ((func == gsp_pkg::FN_REL_RESV) ? gsp_pkg::ST_RESERVED
                                                             : gsp_pkg::ST_LEASED);

  // totals after the step: reserve beat counts use final values
  logic [4:0] tot_res, tot_lea;
  logic [63:0] copy_d;
  logic [2:0]  rs;
  logic [10:0] osz;
  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    copy_d     = copy_q;
    rs         = gsp_pkg::RS_OK;
    osz        = '0;
    tot_res    = 5'(n_res);
    tot_lea    = 5'(n_lea);
    case (state_q)
      S_EVAL: begin
        if (func == gsp_pkg::FN_RESERVE) begin
          if (res_bad) rs = gsp_pkg::RS_INVALID;
          else if (5'(n_free) < bcount) rs = gsp_pkg::RS_EXHAUSTED;
          else state_d = S_SCAN;
        end else if (func == gsp_pkg::FN_COMMIT) begin
          if (com_ok) begin
            cmd.addr_hit   = 1'b1;
            cmd.new_status = gsp_pkg::ST_LEASED;
            copy_d         = copy_q + 64'd1;
            osz            = csize;
            tot_res        = 5'(n_res) - 5'd1;
            tot_lea        = 5'(n_lea) + 5'd1;
          end else rs = gsp_pkg::RS_CONTRACT;
        end else begin
          if (rel_ok) begin
            cmd.addr_hit   = 1'b1;
            cmd.new_status = gsp_pkg::ST_FREE;
            if (func == gsp_pkg::FN_REL_RESV) tot_res = 5'(n_res) - 5'd1;
            else tot_lea = 5'(n_lea) - 5'd1;
          end else rs = gsp_pkg::RS_IGNORED;
        end
        if (state_d != S_SCAN) state_d = S_OUT;
      end
      S_SCAN: begin
        if (!out_v_q || m_axis_tready_i) begin
          cmd.grant = 1'b1;
          // every beat reports totals after the whole reserve
          tot_res = 5'(n_res) + left_q;
          if (left_q == 5'd1) state_d = S_OUT;
        end
      end
      S_OUT: if (!out_v_q || m_axis_tready_i) state_d = S_IDLE;
      default: begin
        if (s_axis_tvalid_i) state_d = S_EVAL;
      end
    endcase
  end

  // reserve beats need the count taken before any claim
  logic [4:0] base_res_q;

  // a new beat enters the output register this cycle
  logic load_beat;
  assign load_beat = (state_q == S_EVAL && state_d != S_SCAN) ||
                     (state_q == S_SCAN && cmd.grant);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= 5'd16;
      copy_q  <= '0;
      out_v_q <= 1'b0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      copy_q  <= copy_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (load_beat) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (state_q == S_IDLE && s_axis_tvalid_i) begin
        in_q   <= s_axis_tdata_i[147:0];
        func_q <= s_axis_tuser_i;
      end
      if (state_q == S_EVAL) begin
        left_q     <= bcount;
        base_res_q <= 5'(n_res) + bcount;
        if (state_d != S_SCAN) begin
          out_last_q <= 1'b1;
          out_q <= {4'd0, copy_d, tot_lea, tot_res, osz,
                    (func == gsp_pkg::FN_RESERVE) ? 64'd0 :
                    (32'(sidx) < SLOTS ? cur_gen : 64'd0),
                    (func == gsp_pkg::FN_RESERVE) ? 4'd0 : sidx,
                    (func == gsp_pkg::FN_RESERVE) ? req_grant : 64'd0, rs};
        end
      end
      if (state_q == S_SCAN && cmd.grant) begin
        left_q     <= left_q - 5'd1;
        out_last_q <= left_q == 5'd1;
        out_q <= {4'd0, copy_q, 5'(n_lea), base_res_q, 11'd0, cgen,
                  4'(cidx), req_grant, gsp_pkg::RS_OK};
      end
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;
endmodule

@@ design/gsp_checker.sv @@
module gsp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [223:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled beat changed");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while busy");
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != 3'd0 |-> m_axis_tlast_o)
    else $error("failure result not last");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[223:220] == 4'd0)
    else $error("pad bits set");
endmodule

bind generational_slot_pool_unit gsp_checker u_gsp_checker (.*);
